>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions with a synchronous reset that disables
// them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk_sig, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> src/esc_pkg.sv
// ----------------------------------------------------------------------------
// Epoch seconds to calendar package
// Shared types, constants and table functions of the converter.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int EPOCH_W = 32;
  localparam int YEAR_W = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W = 5;
  localparam int HOUR_W = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int DAYS_W = 16;
  localparam int REM_W = 6;
  localparam int PROD_W = 2 * EPOCH_W;

  localparam int DIV_STEPS = 2;
  localparam int DIV_STEP_W = $clog2(DIV_STEPS);

  // Reciprocals that give exact quotients for every 32-bit dividend.
  localparam logic [EPOCH_W-1:0] RECIP_60 = 32'h8888_8889;
  localparam logic [EPOCH_W-1:0] RECIP_24 = 32'hAAAA_AAAB;
  localparam int SHIFT_60 = 37;
  localparam int SHIFT_24 = 36;

  localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd1970;
  localparam logic [YEAR_W-1:0] LAST_YEAR = 12'd2106;
  localparam logic [1:0] BASE_MOD4 = 2'd2;
  localparam logic [6:0] BASE_MOD100 = 7'd70;
  localparam logic [8:0] BASE_MOD400 = 9'd370;
  localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DIV_SEC,
    DIV_MIN,
    DIV_HOUR
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_step;
    div_sel_t div_sel;
    logic     div_last;
    logic     year_step;
    logic     month_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } status_t;

  function automatic logic [EPOCH_W-1:0] recip(div_sel_t sel);
    logic [EPOCH_W-1:0] r;
    case (sel)
      DIV_SEC:  r = RECIP_60;
      DIV_MIN:  r = RECIP_60;
      DIV_HOUR: r = RECIP_24;
      default:  r = RECIP_60;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] mon, logic leap);
    logic [DAY_W-1:0] len;
    case (mon)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

>>> src/esc_ctrl.sv
// ----------------------------------------------------------------------------
// Epoch seconds to calendar controller
// Sequences the divide, year and month phases and owns the handshakes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module esc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  esc_pkg::status_t sts,
  output esc_pkg::cmd_t    cmd
);

  esc_pkg::state_t                 state;
  esc_pkg::state_t                 state_next;
  esc_pkg::div_sel_t               phase;
  esc_pkg::div_sel_t               phase_next;
  logic [esc_pkg::DIV_STEP_W-1:0]  step;
  logic                            div_last;
  logic                            slot_free;

  assign div_last  = (step == esc_pkg::DIV_STEP_W'(esc_pkg::DIV_STEPS - 1));
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      esc_pkg::ST_IDLE: begin
        if (in_valid) state_next = esc_pkg::ST_DIV;
      end
      esc_pkg::ST_DIV: begin
        if (div_last && phase == esc_pkg::DIV_HOUR) state_next = esc_pkg::ST_YEAR;
      end
      esc_pkg::ST_YEAR: begin
        if (sts.year_done) state_next = esc_pkg::ST_MONTH;
      end
      esc_pkg::ST_MONTH: begin
        if (sts.month_done) state_next = esc_pkg::ST_DONE;
      end
      esc_pkg::ST_DONE: begin
        if (slot_free) state_next = esc_pkg::ST_IDLE;
      end
      default: state_next = esc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      esc_pkg::DIV_SEC:  phase_next = esc_pkg::DIV_MIN;
      esc_pkg::DIV_MIN:  phase_next = esc_pkg::DIV_HOUR;
      esc_pkg::DIV_HOUR: phase_next = esc_pkg::DIV_SEC;
      default:           phase_next = esc_pkg::DIV_SEC;
    endcase
  end

  always_comb begin
    in_ready       = (state == esc_pkg::ST_IDLE);
    cmd.load       = (state == esc_pkg::ST_IDLE) && in_valid;
    cmd.div_step   = (state == esc_pkg::ST_DIV);
    cmd.div_sel    = phase;
    cmd.div_last   = div_last;
    cmd.year_step  = (state == esc_pkg::ST_YEAR) && !sts.year_done;
    cmd.month_step = (state == esc_pkg::ST_MONTH) && !sts.month_done;
    cmd.out_load   = (state == esc_pkg::ST_DONE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= esc_pkg::ST_IDLE;
      phase     <= esc_pkg::DIV_SEC;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        phase <= esc_pkg::DIV_SEC;
        step  <= '0;
      end else if (cmd.div_step) begin
        step <= step + 1'b1;
        if (div_last) phase <= phase_next;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_SAME(a_step_idle_outside_div, clk, rst, state != esc_pkg::ST_DIV, step == '0)
  `ASSERT_NEXT(a_year_exits_to_month, clk, rst, state == esc_pkg::ST_YEAR, state == esc_pkg::ST_YEAR || state == esc_pkg::ST_MONTH)
  `ASSERT_NEXT(a_done_waits_for_slot, clk, rst, state == esc_pkg::ST_DONE && out_valid && !out_ready, state == esc_pkg::ST_DONE)

endmodule

>>> src/esc_datapath.sv
// ----------------------------------------------------------------------------
// Epoch seconds to calendar datapath
// Shared reciprocal-multiply divider for seconds, minutes and hours, a year
// subtractor with Gregorian leap tracking, a month subtractor and the result
// register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module esc_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  esc_pkg::cmd_t                  cmd,
  output esc_pkg::status_t               sts,
  input  logic [esc_pkg::EPOCH_W-1:0]    epoch_seconds,
  output logic [esc_pkg::YEAR_W-1:0]     year,
  output logic [esc_pkg::MONTH_W-1:0]    month,
  output logic [esc_pkg::DAY_W-1:0]      day,
  output logic [esc_pkg::HOUR_W-1:0]     hour,
  output logic [esc_pkg::MINUTE_W-1:0]   minute,
  output logic [esc_pkg::SECOND_W-1:0]   second
);

  logic [esc_pkg::EPOCH_W-1:0]   quo;
  logic [esc_pkg::PROD_W-1:0]    prod;
  logic [esc_pkg::SECOND_W-1:0]  work_sec;
  logic [esc_pkg::MINUTE_W-1:0]  work_min;
  logic [esc_pkg::HOUR_W-1:0]    work_hour;
  logic [esc_pkg::DAYS_W-1:0]    days;
  logic [esc_pkg::YEAR_W-1:0]    work_year;
  logic [1:0]                    mod4;
  logic [6:0]                    mod100;
  logic [8:0]                    mod400;
  logic [esc_pkg::MONTH_W-1:0]   mon;

  logic [esc_pkg::EPOCH_W-1:0]   div_quo;
  logic [esc_pkg::EPOCH_W-1:0]   div_back;
  logic [esc_pkg::EPOCH_W-1:0]   div_diff;
  logic [esc_pkg::REM_W-1:0]     div_rem;
  logic                          leap;
  logic [8:0]                    ylen;
  logic [esc_pkg::DAY_W-1:0]     mlen;

  always_comb begin
    case (cmd.div_sel)
      esc_pkg::DIV_HOUR: begin
        div_quo  = esc_pkg::EPOCH_W'(prod >> esc_pkg::SHIFT_24);
        div_back = (div_quo << 4) + (div_quo << 3);
      end
      default: begin
        div_quo  = esc_pkg::EPOCH_W'(prod >> esc_pkg::SHIFT_60);
        div_back = (div_quo << 6) - (div_quo << 2);
      end
    endcase
    div_diff = quo - div_back;
    div_rem  = div_diff[esc_pkg::REM_W-1:0];
  end

  always_comb begin
    leap           = (mod4 == 2'd0) && ((mod100 != 7'd0) || (mod400 == 9'd0));
    ylen           = leap ? 9'd366 : 9'd365;
    mlen           = esc_pkg::month_len(mon, leap);
    sts.year_done  = days < {7'd0, ylen};
    sts.month_done = (mon == esc_pkg::LAST_MONTH) || (days < {11'd0, mlen});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo       <= epoch_seconds;
      work_year <= esc_pkg::BASE_YEAR;
      mod4      <= esc_pkg::BASE_MOD4;
      mod100    <= esc_pkg::BASE_MOD100;
      mod400    <= esc_pkg::BASE_MOD400;
      mon       <= '0;
    end else if (cmd.div_step) begin
      if (cmd.div_last) begin
        quo <= div_quo;
        case (cmd.div_sel)
          esc_pkg::DIV_SEC:  work_sec <= div_rem;
          esc_pkg::DIV_MIN:  work_min <= div_rem;
          esc_pkg::DIV_HOUR: begin
            work_hour <= div_rem[esc_pkg::HOUR_W-1:0];
            days      <= div_quo[esc_pkg::DAYS_W-1:0];
          end
          default: work_sec <= div_rem;
        endcase
      end else begin
        prod <= esc_pkg::PROD_W'(quo) * esc_pkg::PROD_W'(esc_pkg::recip(cmd.div_sel));
      end
    end else if (cmd.year_step) begin
      days      <= days - {7'd0, ylen};
      work_year <= work_year + 1'b1;
      mod4      <= mod4 + 1'b1;
      mod100    <= (mod100 == 7'd99) ? 7'd0 : mod100 + 1'b1;
      mod400    <= (mod400 == 9'd399) ? 9'd0 : mod400 + 1'b1;
    end else if (cmd.month_step) begin
      days <= days - {11'd0, mlen};
      mon  <= mon + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      year   <= work_year;
      month  <= mon + 1'b1;
      day    <= days[esc_pkg::DAY_W-1:0] + 1'b1;
      hour   <= work_hour;
      minute <= work_min;
      second <= work_sec;
    end
  end

  `ASSERT_SAME(a_month_step_in_range, clk, rst, cmd.month_step, mon < esc_pkg::LAST_MONTH)
  `ASSERT_SAME(a_year_step_in_range, clk, rst, cmd.year_step, work_year < esc_pkg::LAST_YEAR)
  `ASSERT_SAME(a_result_day_fits, clk, rst, cmd.out_load, days < {11'd0, mlen})

endmodule

>>> src/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// Epoch seconds to calendar
// Converts an unsigned count of seconds since 1970-01-01 00:00:00 UTC into
// Gregorian year, month, day, hour, minute and second.
// ----------------------------------------------------------------------------
// One transaction at a time: after an input transaction the block divides by
// 60, 60 and 24 with a shared reciprocal multiplier, each divide a multiply
// step followed by a quotient and remainder step, then subtracts one whole
// year per cycle from 1970 on, then one month per cycle, and moves the result
// into the output register once that register is free, waiting while a
// result there has not been taken. It returns to idle before it accepts the
// next input transaction. The output register holds a finished result while
// the next item is accepted and computed.
module epoch_seconds_to_calendar (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [esc_pkg::EPOCH_W-1:0]    epoch_seconds,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [esc_pkg::YEAR_W-1:0]     year,
  output logic [esc_pkg::MONTH_W-1:0]    month,
  output logic [esc_pkg::DAY_W-1:0]      day,
  output logic [esc_pkg::HOUR_W-1:0]     hour,
  output logic [esc_pkg::MINUTE_W-1:0]   minute,
  output logic [esc_pkg::SECOND_W-1:0]   second
);

  esc_pkg::cmd_t    cmd;
  esc_pkg::status_t sts;

  esc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  esc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .epoch_seconds (epoch_seconds),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second)
  );

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// Epoch seconds to calendar testbench
// Drives epoch second counts into the converter and checks every date and
// time of day against a behavioral calendar computed in the bench. It covers
// boundary dates, the full input range, random traffic under sender gaps and
// receiver stalls, and a long output stall that fills the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int RESET_CYCLES = 12;
  localparam int LONG_STALL_CYCLES = 800;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASE_ITEMS = 230;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [esc_pkg::YEAR_W-1:0]   year;
    logic [esc_pkg::MONTH_W-1:0]  month;
    logic [esc_pkg::DAY_W-1:0]    day;
    logic [esc_pkg::HOUR_W-1:0]   hour;
    logic [esc_pkg::MINUTE_W-1:0] minute;
    logic [esc_pkg::SECOND_W-1:0] second;
  } calendar_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [esc_pkg::EPOCH_W-1:0]  epoch_seconds = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [esc_pkg::YEAR_W-1:0]   year;
  logic [esc_pkg::MONTH_W-1:0]  month;
  logic [esc_pkg::DAY_W-1:0]    day;
  logic [esc_pkg::HOUR_W-1:0]   hour;
  logic [esc_pkg::MINUTE_W-1:0] minute;
  logic [esc_pkg::SECOND_W-1:0] second;

  calendar_t   pending_dates[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_start = 1'b0;
  int unsigned stall_count = 0;
  int unsigned mismatches = 0;

  epoch_seconds_to_calendar dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .epoch_seconds (epoch_seconds),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic calendar_t to_calendar(logic [esc_pkg::EPOCH_W-1:0] secs);
    int unsigned mdays[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int unsigned t;
    int unsigned days;
    int unsigned y;
    int unsigned m;
    int unsigned len;
    calendar_t   c;
    t = secs;
    c.second = esc_pkg::SECOND_W'(t % 60);
    t = t / 60;
    c.minute = esc_pkg::MINUTE_W'(t % 60);
    t = t / 60;
    c.hour = esc_pkg::HOUR_W'(t % 24);
    days = t / 24;
    y = 1970;
    forever begin
      len = is_leap_year(y) ? 366 : 365;
      if (days < len) break;
      days -= len;
      y++;
    end
    m = 0;
    while (m < 11) begin
      len = (m == 1 && is_leap_year(y)) ? 29 : mdays[m];
      if (days < len) break;
      days -= len;
      m++;
    end
    c.year = esc_pkg::YEAR_W'(y);
    c.month = esc_pkg::MONTH_W'(m + 1);
    c.day = esc_pkg::DAY_W'(days + 1);
    return c;
  endfunction

  function automatic logic [esc_pkg::EPOCH_W-1:0] pick_epoch();
    int unsigned kind;
    logic [63:0] t;
    kind = $urandom_range(99);
    if (kind < 60) return $urandom();
    if (kind < 80) return $urandom_range(32'h03FF_FFFF);
    // Land on either side of a midnight somewhere in the whole range.
    t = 64'($urandom_range(49710)) * 64'd86400 + 64'($urandom_range(2)) - 64'd1;
    if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
    return t[esc_pkg::EPOCH_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (hold_start) begin
      stall_count <= LONG_STALL_CYCLES;
      out_ready <= 1'b0;
    end else if (stall_count != 0) begin
      stall_count <= stall_count - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    calendar_t got;
    calendar_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{year, month, day, hour, minute, second};
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result %0d-%0d-%0d %0d:%0d:%0d", got.year, got.month,
                   got.day, got.hour, got.minute, got.second);
      end else begin
        want = pending_dates.pop_front();
        if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
            got.hour !== want.hour || got.minute !== want.minute ||
            got.second !== want.second) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d",
                     want.year, want.month, want.day, want.hour, want.minute, want.second,
                     got.year, got.month, got.day, got.hour, got.minute, got.second);
        end
      end
    end
  end

  task automatic send_epoch(input logic [esc_pkg::EPOCH_W-1:0] value);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    epoch_seconds <= value;
    do @(posedge clk); while (!in_ready);
    pending_dates.push_back(to_calendar(value));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_dates();
    logic [esc_pkg::EPOCH_W-1:0] dates[$];
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    // The epoch itself, the largest count, and the rollovers of each unit.
    dates = '{32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
              32'd86400, 32'd2678399, 32'd2678400, 32'd31535999, 32'd31536000,
              // Leap days in 1972 and 2000, and the last second of leap years.
              32'd68083199, 32'd68169600, 32'd94694399, 32'd951782400, 32'd978307199,
              // The year 2100 is not a leap year.
              32'd4107542399, 32'd4107542400, 32'd2147483647, 32'd2147483648,
              32'hAAAA_AAAA, 32'h5555_5555};
    foreach (dates[i]) send_epoch(dates[i]);
    wait_for_results();
  endtask

  task automatic test_random_dates(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
    repeat (PHASE_ITEMS) send_epoch(pick_epoch());
    wait_for_results();
  endtask

  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    repeat (12) send_epoch(pick_epoch());
    wait_for_results();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_directed_dates();
    test_random_dates(0, 0);
    test_random_dates(53, 0);
    test_random_dates(0, 53);
    test_random_dates(12, 12);
    test_output_hold_off();
    recv_stall_pct <= 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_dates.size() == 0) begin
      $display("epoch_seconds_to_calendar test passed");
    end else begin
      $display("epoch_seconds_to_calendar test failed");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("epoch_seconds_to_calendar test failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/esc_pkg.sv
src/esc_ctrl.sv
src/esc_datapath.sv
src/epoch_seconds_to_calendar.sv
sim/tb_top.sv
